### hw/rtl/dma_pkg.sv
`default_nettype none
// ============================================================================
// dma_pkg - shared types and constants of the deadband moving average core
// Word formats of the request and response channels, field widths and the
// default window depth.
// ============================================================================
package dma_pkg;

   localparam int SAMPLE_W       = 24;
   localparam int MIN_CHANGE_W   = 23;
   localparam int DEFAULT_WINDOW = 8;
   // samples that must be held before the deadband may keep the old mean
   localparam int MIN_HELD       = 3;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] sample;
   } dma_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       held;
   } dma_rsp_type;

endpackage : dma_pkg
`default_nettype wire

### hw/rtl/dma_ram.sv
`default_nettype none
// ============================================================================
// dma_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module dma_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule : dma_ram
`default_nettype wire

### hw/rtl/dma_div.sv
`default_nettype none
// ============================================================================
// dma_div - serial signed divider, one quotient bit per cycle
// Divides a signed sum by an unsigned count, quotient truncated toward zero
// and cut to sample width.
// ============================================================================
module dma_div
   import dma_pkg::*;
#(
   parameter int NUM_W = 27,
   parameter int DEN_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [NUM_W-1:0]    numer,
   input  wire logic        [DEN_W-1:0]    denom,
   output logic                            done_ff,
   output logic signed      [SAMPLE_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DEN_W:0]    rem_shift;
   logic [NUM_W-1:0]  quot_signed;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      rem_shift = {rem_ff, dvd_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         neg_in  = numer[NUM_W-1];
         dvd_in  = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         // restoring step: shift in the next dividend bit, subtract if it fits
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_shift - {1'b0, den_ff});
            dvd_in = {dvd_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            dvd_in = {dvd_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quot_signed = neg_ff ? NUM_W'(-dvd_ff) : dvd_ff;
   assign quotient    = quot_signed[SAMPLE_W-1:0];

endmodule : dma_div
`default_nettype wire

### hw/rtl/deadband_moving_average_core.sv
`default_nettype none
// ============================================================================
// deadband_moving_average_core - windowed moving average with a deadband
// Top level: request sequencer, sample ring, running sum and serial divider.
// ============================================================================
// A filter word (op = 0) on an empty history stores the sample and returns it
// as is; the result passes through ST_DONE into the output register, where
// the response word becomes valid, and the next request can be taken once the
// core is back in ST_IDLE. With at least three samples held, the sample is
// first compared with the current mean: a difference below min_change returns
// that mean with held set and stores nothing. Otherwise the sample enters the
// ring, the oldest drops out once WINDOW are held, and the new mean goes out.
// Means come from one serial divider (SUM_W = 24 + clog2(WINDOW), 27 for a
// window of eight). A word with one or two samples held, or with the sample
// kept out by the deadband, needs one division; a word that checks the old
// mean and then computes a new one needs two. The divider sets the rate. A
// clear word (op = 1) empties the history as it is accepted and gives no
// response. req_stall is high while a word is being worked on; a finished
// response waits in the output register, so the next request is taken
// meanwhile, and only a second finished word waiting behind a stalled
// response adds stall cycles. min_change is written through the csr port,
// which is always ready.
module deadband_moving_average_core
   import dma_pkg::*;
#(
   parameter int WINDOW = DEFAULT_WINDOW
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire dma_req_type             req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output dma_rsp_type                  rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [MIN_CHANGE_W-1:0] csr_data
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int POS_W = CNT_W + 1;
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
   localparam int DIF_W = SAMPLE_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_CHECK,
      ST_UPDATE,
      ST_AVG,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [MIN_CHANGE_W-1:0]    min_change_ff, min_change_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   dma_rsp_type                result_ff, result_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   dma_rsp_type                rsp_data_ff, rsp_data_in;

   logic                       req_accept;
   logic                       enough_held;
   logic                       div_start;
   logic                       div_done;
   logic signed [SUM_W-1:0]    div_numer;
   logic [CNT_W-1:0]           div_denom;
   logic signed [SAMPLE_W-1:0] div_quot;

   logic                       ram_we;
   logic [IDX_W-1:0]           ram_waddr;
   logic [SAMPLE_W-1:0]        ram_wdata;
   logic [SAMPLE_W-1:0]        ram_rdata;

   logic [POS_W-1:0]           tail_pos;
   logic signed [DIF_W-1:0]    diff;
   logic [DIF_W-1:0]           abs_diff;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign enough_held = (32'(count_ff) >= MIN_HELD);

   // ring slot just past the newest sample, wrapped once
   always_comb begin
      tail_pos = POS_W'(head_ff) + POS_W'(count_ff);
      if (tail_pos >= POS_W'(WINDOW)) begin
         tail_pos = tail_pos - POS_W'(WINDOW);
      end
   end

   assign diff     = DIF_W'(sample_ff) - DIF_W'(mean_ff);
   assign abs_diff = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      min_change_in = min_change_ff;
      sample_in     = sample_ff;
      mean_in       = mean_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_numer     = sum_ff;
      div_denom     = count_ff;
      ram_we        = 1'b0;
      ram_waddr     = head_ff;
      ram_wdata     = sample_ff;

      // take the configuration word whenever offered
      if (csr_valid && csr_ready) begin
         min_change_in = csr_data;
      end

      // drop the response once the far side has taken it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sample_in = req_data.sample;
               if (req_data.op == OP_CLEAR) begin
                  count_in = '0;
                  head_in  = '0;
                  sum_in   = '0;
               end else if (count_ff == '0) begin
                  // first sample: store it at slot zero and return it
                  ram_we             = 1'b1;
                  ram_waddr          = '0;
                  ram_wdata          = req_data.sample;
                  head_in            = '0;
                  count_in           = CNT_W'(1);
                  sum_in             = SUM_W'(req_data.sample);
                  result_in.filtered = req_data.sample;
                  result_in.held     = 1'b0;
                  state_in           = ST_DONE;
               end else if (enough_held) begin
                  div_start = 1'b1;
                  state_in  = ST_MEAN;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_MEAN: begin
            if (div_done) begin
               mean_in  = div_quot;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (abs_diff < DIF_W'(min_change_ff)) begin
               // inside the deadband: keep the old mean, discard the sample
               result_in.filtered = mean_ff;
               result_in.held     = 1'b1;
               state_in           = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ram_we = 1'b1;
            if (count_ff < CNT_W'(WINDOW)) begin
               // append behind the newest sample
               ram_waddr = tail_pos[IDX_W-1:0];
               count_in  = count_ff + 1'b1;
               sum_in    = sum_ff + SUM_W'(sample_ff);
            end else begin
               // full ring: overwrite the oldest, whose value the read port holds
               ram_waddr = head_ff;
               sum_in    = sum_ff - SUM_W'($signed(ram_rdata)) + SUM_W'(sample_ff);
               if (head_ff == IDX_W'(WINDOW - 1)) begin
                  head_in = '0;
               end else begin
                  head_in = head_ff + 1'b1;
               end
            end
            div_start = 1'b1;
            div_numer = sum_in;
            div_denom = count_in;
            state_in  = ST_AVG;
         end
         ST_AVG: begin
            if (div_done) begin
               result_in.filtered = div_quot;
               result_in.held     = 1'b0;
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         sum_ff        <= '0;
         min_change_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         sum_ff        <= sum_in;
         min_change_ff <= min_change_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      mean_ff     <= mean_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   // read port always follows the oldest slot, so its value is ready on update
   dma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_addr    (head_ff),
      .rd_data_ff (ram_rdata)
   );

   dma_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done_ff  (div_done),
      .quotient (div_quot)
   );

endmodule : deadband_moving_average_core
`default_nettype wire
